// ===== hw/rtl/yiq_hue_rotate_assert.svh =====
// Assertion macros for the YIQ hue rotation block.
`ifndef YIQ_HUE_ROTATE_ASSERT_SVH
`define YIQ_HUE_ROTATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define YHR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define YHR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define YHR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define YHR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/yhr_pkg.sv =====
// Shared types, constants and coefficient helper for the YIQ hue rotation block.
`default_nettype none

package yhr_pkg;

   localparam int COEF_FRAC_BITS  = 14;
   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ANGLE_W         = 16;
   localparam int PIX_W           = 8;

   localparam logic CSR_COS_ANGLE = 1'b0;
   localparam logic CSR_SIN_ANGLE = 1'b1;

   localparam logic signed [ANGLE_W-1:0] COS_RESET = 16'sd16384;
   localparam logic signed [ANGLE_W-1:0] SIN_RESET = 16'sd0;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] cos_angle;
      logic signed [ANGLE_W-1:0] sin_angle;
   } angle_type;

   function automatic longint coef(input longint milli, input int frac_bits);
      longint scaled;
      scaled = milli * (longint'(1) << frac_bits);
      if (milli >= 0) begin
         return (scaled + 500) / 1000;
      end else begin
         return (scaled - 500) / 1000;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yiq_hue_rotate.sv =====
// An accepted req transaction passes through every pipeline stage, one per register, before rsp_tvalid.
// Throughput: one pixel per clock; a stall on rsp holds the occupied stages back to the first empty one.
// The ready chain back from rsp_tready fills bubbles, so empty stages never block input.
// Reset (synchronous, active high) empties the pipeline and sets cos_angle to 1.0, sin_angle 0.
// Top level: angle registers, stream packing and the YIQ rotation pipeline.
`default_nettype none

module yiq_hue_rotate #(
   parameter int COEF_FRAC_BITS = yhr_pkg::COEF_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   yhr_pkg::angle_type angle_ff;
   yhr_pkg::angle_type angle_in;
   yhr_pkg::pixel_type in_pix;
   yhr_pkg::pixel_type out_pix;

   always_comb begin
      angle_in = angle_ff;
      if (csr_we) begin
         case (csr_index)
            yhr_pkg::CSR_COS_ANGLE: angle_in.cos_angle = $signed(csr_wdata);
            yhr_pkg::CSR_SIN_ANGLE: angle_in.sin_angle = $signed(csr_wdata);
            default: angle_in = angle_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff.cos_angle <= yhr_pkg::COS_RESET;
         angle_ff.sin_angle <= yhr_pkg::SIN_RESET;
      end else begin
         angle_ff <= angle_in;
      end
   end

   assign in_pix.red   = req_tdata[7:0];
   assign in_pix.green = req_tdata[15:8];
   assign in_pix.blue  = req_tdata[23:16];

   yhr_pipe #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (in_pix),
      .angle     (angle_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix)
   );

   assign rsp_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

`default_nettype wire

// ===== hw/rtl/yhr_pipe.sv =====
// Six-stage datapath: RGB to YIQ, IQ rotation, YIQ to RGB, clamp.
`default_nettype none

`include "yiq_hue_rotate_assert.svh"

module yhr_pipe #(
   parameter int COEF_FRAC_BITS = yhr_pkg::COEF_FRAC_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire yhr_pkg::pixel_type  in_pix,
   input  wire yhr_pkg::angle_type  angle,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output yhr_pkg::pixel_type       out_pix
);

   localparam int F      = COEF_FRAC_BITS;
   localparam int AF     = yhr_pkg::ANGLE_FRAC_BITS;
   localparam int W_YIQ  = F + 10;
   localparam int W_P1   = F + 27;
   localparam int W_ROT  = F + 12;
   localparam int W_ACC  = 2 * F + 18;
   localparam int NSTAGE = 6;

   localparam logic signed [W_YIQ-1:0] C_YR = W_YIQ'(yhr_pkg::coef(299, F));
   localparam logic signed [W_YIQ-1:0] C_YG = W_YIQ'(yhr_pkg::coef(587, F));
   localparam logic signed [W_YIQ-1:0] C_YB = W_YIQ'(yhr_pkg::coef(114, F));
   localparam logic signed [W_YIQ-1:0] C_IR = W_YIQ'(yhr_pkg::coef(596, F));
   localparam logic signed [W_YIQ-1:0] C_IG = W_YIQ'(yhr_pkg::coef(-274, F));
   localparam logic signed [W_YIQ-1:0] C_IB = W_YIQ'(yhr_pkg::coef(-321, F));
   localparam logic signed [W_YIQ-1:0] C_QR = W_YIQ'(yhr_pkg::coef(211, F));
   localparam logic signed [W_YIQ-1:0] C_QG = W_YIQ'(yhr_pkg::coef(-523, F));
   localparam logic signed [W_YIQ-1:0] C_QB = W_YIQ'(yhr_pkg::coef(311, F));

   localparam logic signed [W_ACC-1:0] C_RI = W_ACC'(yhr_pkg::coef(956, F));
   localparam logic signed [W_ACC-1:0] C_RQ = W_ACC'(yhr_pkg::coef(621, F));
   localparam logic signed [W_ACC-1:0] C_GI = W_ACC'(yhr_pkg::coef(-272, F));
   localparam logic signed [W_ACC-1:0] C_GQ = W_ACC'(yhr_pkg::coef(-647, F));
   localparam logic signed [W_ACC-1:0] C_BI = W_ACC'(yhr_pkg::coef(-1107, F));
   localparam logic signed [W_ACC-1:0] C_BQ = W_ACC'(yhr_pkg::coef(1705, F));

   localparam logic signed [W_ACC-1:0] CLAMP_MAX =
      {{(W_ACC-8){1'b0}}, 8'd255} << (2 * F);

   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] adv;

   logic signed [W_YIQ-1:0] px_r, px_g, px_b;
   logic signed [W_YIQ-1:0] y0_ff, i0_ff, q0_ff;
   logic signed [W_YIQ-1:0] y0_in, i0_in, q0_in;

   logic signed [W_P1-1:0]  i_ext, q_ext, c_ext, s_ext;
   logic signed [W_P1-1:0]  ic_ff, qs_ff, is_ff, qc_ff;
   logic signed [W_P1-1:0]  ic_in, qs_in, is_in, qc_in;
   logic signed [W_YIQ-1:0] y1_ff;

   logic signed [W_P1-1:0]  idiff, qsum;
   logic signed [W_ROT-1:0] ir_ff, qr_ff, ir_in, qr_in;
   logic signed [W_YIQ-1:0] y2_ff;

   logic signed [W_ACC-1:0] ir_ext, qr_ext;
   logic signed [W_ACC-1:0] ri_ff, rq_ff, gi_ff, gq_ff, bi_ff, bq_ff, ys_ff;
   logic signed [W_ACC-1:0] ri_in, rq_in, gi_in, gq_in, bi_in, bq_in, ys_in;

   logic signed [W_ACC-1:0] racc_ff, gacc_ff, bacc_ff;
   logic signed [W_ACC-1:0] racc_in, gacc_in, bacc_in;

   yhr_pkg::pixel_type out_ff, out_in;

   function automatic logic [7:0] clamp8(input logic signed [W_ACC-1:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > CLAMP_MAX) begin
         res = 8'd255;
      end else begin
         res = v[2*F+7:2*F];
      end
      return res;
   endfunction

   assign adv[5] = !vld_ff[5] || out_ready;
   assign adv[4] = !vld_ff[4] || adv[5];
   assign adv[3] = !vld_ff[3] || adv[4];
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];

   assign vld_in = {vld_ff[NSTAGE-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_comb begin
      px_r  = W_YIQ'($signed({1'b0, in_pix.red}));
      px_g  = W_YIQ'($signed({1'b0, in_pix.green}));
      px_b  = W_YIQ'($signed({1'b0, in_pix.blue}));
      y0_in = C_YR * px_r + C_YG * px_g + C_YB * px_b;
      i0_in = C_IR * px_r + C_IG * px_g + C_IB * px_b;
      q0_in = C_QR * px_r + C_QG * px_g + C_QB * px_b;
   end

   always_comb begin
      i_ext = W_P1'(i0_ff);
      q_ext = W_P1'(q0_ff);
      c_ext = W_P1'(angle.cos_angle);
      s_ext = W_P1'(angle.sin_angle);
      ic_in = i_ext * c_ext;
      qs_in = q_ext * s_ext;
      is_in = i_ext * s_ext;
      qc_in = q_ext * c_ext;
   end

   always_comb begin
      idiff = ic_ff - qs_ff;
      qsum  = is_ff + qc_ff;
      ir_in = W_ROT'(idiff >>> AF);
      qr_in = W_ROT'(qsum >>> AF);
   end

   always_comb begin
      ir_ext = W_ACC'(ir_ff);
      qr_ext = W_ACC'(qr_ff);
      ri_in  = ir_ext * C_RI;
      rq_in  = qr_ext * C_RQ;
      gi_in  = ir_ext * C_GI;
      gq_in  = qr_ext * C_GQ;
      bi_in  = ir_ext * C_BI;
      bq_in  = qr_ext * C_BQ;
      ys_in  = W_ACC'(y2_ff) <<< F;
   end

   always_comb begin
      racc_in = ys_ff + ri_ff + rq_ff;
      gacc_in = ys_ff + gi_ff + gq_ff;
      bacc_in = ys_ff + bi_ff + bq_ff;
   end

   always_comb begin
      out_in.red   = clamp8(racc_ff);
      out_in.green = clamp8(gacc_ff);
      out_in.blue  = clamp8(bacc_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         y0_ff <= y0_in;
         i0_ff <= i0_in;
         q0_ff <= q0_in;
      end
      if (adv[1]) begin
         ic_ff <= ic_in;
         qs_ff <= qs_in;
         is_ff <= is_in;
         qc_ff <= qc_in;
         y1_ff <= y0_ff;
      end
      if (adv[2]) begin
         ir_ff <= ir_in;
         qr_ff <= qr_in;
         y2_ff <= y1_ff;
      end
      if (adv[3]) begin
         ri_ff <= ri_in;
         rq_ff <= rq_in;
         gi_ff <= gi_in;
         gq_ff <= gq_in;
         bi_ff <= bi_in;
         bq_ff <= bq_in;
         ys_ff <= ys_in;
      end
      if (adv[4]) begin
         racc_ff <= racc_in;
         gacc_ff <= gacc_in;
         bacc_ff <= bacc_in;
      end
      if (adv[5]) begin
         out_ff <= out_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[5];
   assign out_pix   = out_ff;

   `YHR_ASSERT_NEXT(a_accept_loads, clock, reset, in_valid && in_ready, vld_ff[0], "accepted transaction not captured")
   `YHR_ASSERT_NEXT(a_mid_hold, clock, reset, vld_ff[2] && !adv[2], vld_ff[2] && $stable(ir_ff) && $stable(qr_ff), "stalled rotation stage changed")
   `YHR_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_ff), "stalled result changed")
   `YHR_ASSERT_IMPLY(a_ready_when_drained, clock, reset, !vld_ff[5], in_ready, "pipeline blocked with empty output stage")

endmodule

`default_nettype wire
